>>> src/fbrgb_pkg.sv
// ----------------------------------------------------------------------------
// fbrgb_pkg
// Shared types, constants and helper functions of the framebuffer row to
// RGB888 converter.
// ----------------------------------------------------------------------------
package fbrgb_pkg;

    localparam int MAX_ROW_PIXELS  = 4096;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam int MAX_PLANES   = 8;
    localparam int WORD_W       = 16;
    localparam int COLOR_W      = 24;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int COL_W        = 13;
    localparam int ENTRY_DATA_W = MAX_PLANES * WORD_W;

    localparam logic [2:0] FMT_MONO   = 3'd0;
    localparam logic [2:0] FMT_TWO    = 3'd1;
    localparam logic [2:0] FMT_FOUR   = 3'd2;
    localparam logic [2:0] FMT_EIGHT  = 3'd3;
    localparam logic [2:0] FMT_CHUNKY = 3'd4;
    localparam logic [2:0] FMT_RGB565 = 3'd5;
    localparam logic [2:0] FMT_RGB24  = 3'd6;
    localparam logic [2:0] FMT_XRGB32 = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WORDS    = 2'd2;

    localparam logic [2:0] OP_PALETTE = 3'd0;
    localparam logic [2:0] OP_MONO    = 3'd1;
    localparam logic [2:0] OP_PLANAR  = 3'd2;
    localparam logic [2:0] OP_CHUNKY  = 3'd3;
    localparam logic [2:0] OP_DIRECT  = 3'd4;

    localparam logic [0:0] KIND_DATA    = 1'b0;
    localparam logic [0:0] KIND_PALETTE = 1'b1;

    typedef struct packed {
        logic [0:0]  kind;
        logic [15:0] data_word;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       single_component;
        logic       row_end;
        logic       batch_end;
    } out_item_t;

    typedef struct packed {
        logic [2:0]              op;
        logic [1:0]              plane_log;
        logic [3:0]              last_pix;
        logic                    row_end;
        logic [ENTRY_DATA_W-1:0] data;
    } q_entry_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

endpackage

>>> src/fbrgb_ram.sv
// ----------------------------------------------------------------------------
// fbrgb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbrgb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fbrgb_front.sv
// ----------------------------------------------------------------------------
// fbrgb_front
// Accepts source words, keeps the configuration and the row position,
// gathers plane groups and staged bytes, and queues pixel batches and palette writes.
// ----------------------------------------------------------------------------
module fbrgb_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  src_valid,
    output logic                                  src_stall,
    input  fbrgb_pkg::in_item_t                   src_data,
    input  logic                                  cfg_write_en,
    input  logic [fbrgb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbrgb_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                  q_full,
    output logic                                  q_push,
    output fbrgb_pkg::q_entry_t                   q_entry
);

    logic [2:0]                      fmt_reg, fmt_next;
    logic [12:0]                     rpix_reg, rpix_next;
    logic [8:0]                      rwpp_reg, rwpp_next;
    logic [fbrgb_pkg::COL_W-1:0]     col_reg, col_next;
    logic [12:0]                     rwc_reg, rwc_next;
    logic [2:0]                      wig_reg, wig_next;
    logic [15:0]                     stage_reg, stage_next;
    logic [1:0]                      scnt_reg, scnt_next;
    logic [fbrgb_pkg::WORD_W-1:0]    pbuf_reg [fbrgb_pkg::MAX_PLANES];

    logic                            accept;
    logic                            data_acc;
    logic [15:0]                     w;
    logic [8:0]                      wpp_c;
    logic [12:0]                     rp_c;
    logic [12:0]                     slots;
    logic [12:0]                     vis;
    logic [13:0]                     limit;
    logic [1:0]                      plog;
    logic [2:0]                      plane_last;
    logic                            have_px;
    logic [4:0]                      npix;
    logic [12:0]                     rem;
    logic [4:0]                      nemit;
    logic [4:0]                      nemit_m1;
    logic [2:0]                      op;
    logic [23:0]                     direct;
    logic [fbrgb_pkg::ENTRY_DATA_W-1:0] group;
    logic                            restart;
    logic                            cfg_hit;

    assign src_stall = q_full;
    assign accept    = src_valid && !src_stall;
    assign data_acc  = accept && (src_data.kind == fbrgb_pkg::KIND_DATA);
    assign w         = src_data.data_word;
    assign cfg_hit   = cfg_write_en && (cfg_index <= fbrgb_pkg::REG_ROW_WORDS);

    always_comb
    begin
        if (rwpp_reg == 9'd0)
        begin
            wpp_c = 9'd1;
        end
        else if (rwpp_reg > 9'd256)
        begin
            wpp_c = 9'd256;
        end
        else
        begin
            wpp_c = rwpp_reg;
        end
        if (rpix_reg == 13'd0)
        begin
            rp_c = 13'd1;
        end
        else if (rpix_reg > 13'(fbrgb_pkg::MAX_ROW_PIXELS))
        begin
            rp_c = 13'(fbrgb_pkg::MAX_ROW_PIXELS);
        end
        else
        begin
            rp_c = rpix_reg;
        end
        slots = {wpp_c[8:0], 4'b0000};
        vis   = (rp_c < slots) ? rp_c : slots;
    end

    always_comb
    begin
        case (fmt_reg)
            fbrgb_pkg::FMT_MONO:   limit = {5'b0, wpp_c};
            fbrgb_pkg::FMT_TWO:    limit = {4'b0, wpp_c, 1'b0};
            fbrgb_pkg::FMT_FOUR:   limit = {3'b0, wpp_c, 2'b0};
            fbrgb_pkg::FMT_EIGHT,
            fbrgb_pkg::FMT_CHUNKY: limit = {2'b0, wpp_c, 3'b0};
            fbrgb_pkg::FMT_RGB565: limit = {1'b0, wpp_c, 4'b0};
            fbrgb_pkg::FMT_RGB24:  limit = {1'b0, wpp_c, 4'b0} + {2'b0, wpp_c, 3'b0};
            fbrgb_pkg::FMT_XRGB32: limit = {wpp_c, 5'b0};
            default:               limit = {5'b0, wpp_c};
        endcase
    end

    always_comb
    begin
        case (fmt_reg)
            fbrgb_pkg::FMT_TWO:   plog = 2'd1;
            fbrgb_pkg::FMT_FOUR:  plog = 2'd2;
            fbrgb_pkg::FMT_EIGHT: plog = 2'd3;
            default:              plog = 2'd0;
        endcase
        plane_last = 3'((4'd1 << plog) - 4'd1);
        for (int k = 0; k < fbrgb_pkg::MAX_PLANES; k++)
        begin
            group[k*fbrgb_pkg::WORD_W +: fbrgb_pkg::WORD_W] =
                (3'(k) == wig_reg) ? w : pbuf_reg[k];
        end
    end

    always_comb
    begin
        have_px    = 1'b0;
        npix       = 5'd1;
        op         = fbrgb_pkg::OP_DIRECT;
        direct     = 24'd0;
        wig_next   = wig_reg;
        stage_next = stage_reg;
        scnt_next  = scnt_reg;
        case (fmt_reg)
            fbrgb_pkg::FMT_MONO:
            begin
                have_px = 1'b1;
                npix    = 5'd16;
                op      = fbrgb_pkg::OP_MONO;
            end
            fbrgb_pkg::FMT_TWO, fbrgb_pkg::FMT_FOUR, fbrgb_pkg::FMT_EIGHT:
            begin
                op   = fbrgb_pkg::OP_PLANAR;
                npix = 5'd16;
                if (wig_reg == plane_last)
                begin
                    have_px  = 1'b1;
                    wig_next = 3'd0;
                end
                else
                begin
                    wig_next = wig_reg + 3'd1;
                end
            end
            fbrgb_pkg::FMT_CHUNKY:
            begin
                have_px = 1'b1;
                npix    = 5'd2;
                op      = fbrgb_pkg::OP_CHUNKY;
            end
            fbrgb_pkg::FMT_RGB565:
            begin
                have_px = 1'b1;
                direct  = {fbrgb_pkg::widen5(w[15:11]), fbrgb_pkg::widen6(w[10:5]),
                           fbrgb_pkg::widen5(w[4:0])};
            end
            fbrgb_pkg::FMT_RGB24:
            begin
                case (scnt_reg)
                    2'd0:
                    begin
                        stage_next = w;
                        scnt_next  = 2'd2;
                    end
                    2'd1:
                    begin
                        have_px    = 1'b1;
                        direct     = {stage_reg[7:0], w};
                        stage_next = 16'd0;
                        scnt_next  = 2'd0;
                    end
                    default:
                    begin
                        have_px    = 1'b1;
                        direct     = {stage_reg, w[15:8]};
                        stage_next = {8'd0, w[7:0]};
                        scnt_next  = 2'd1;
                    end
                endcase
            end
            default:
            begin
                if (wig_reg == 3'd0)
                begin
                    stage_next = {8'd0, w[7:0]};
                    scnt_next  = 2'd1;
                    wig_next   = 3'd1;
                end
                else
                begin
                    have_px    = 1'b1;
                    direct     = {stage_reg[7:0], w};
                    stage_next = 16'd0;
                    scnt_next  = 2'd0;
                    wig_next   = 3'd0;
                end
            end
        endcase
    end

    always_comb
    begin
        rem      = vis - col_reg;
        nemit    = ({8'd0, npix} <= rem) ? npix : rem[4:0];
        nemit_m1 = nemit - 5'd1;
        restart  = ({1'b0, rwc_reg} + 14'd1) >= limit;
        rwc_next = rwc_reg + 13'd1;
        col_next = col_reg + (have_px ? {8'd0, npix} : 13'd0);
    end

    always_comb
    begin
        q_entry           = '0;
        q_push            = 1'b0;
        q_entry.plane_log = plog;
        if (accept && (src_data.kind == fbrgb_pkg::KIND_PALETTE))
        begin
            q_push          = 1'b1;
            q_entry.op      = fbrgb_pkg::OP_PALETTE;
            q_entry.data    = {{(fbrgb_pkg::ENTRY_DATA_W-32){1'b0}},
                               src_data.palette_index, src_data.palette_color};
        end
        else if (data_acc && have_px && (col_reg < vis))
        begin
            q_push           = 1'b1;
            q_entry.op       = op;
            q_entry.last_pix = nemit_m1[3:0];
            q_entry.row_end  = ({8'd0, npix} >= rem);
            if (op == fbrgb_pkg::OP_PLANAR)
            begin
                q_entry.data = group;
            end
            else if (op == fbrgb_pkg::OP_DIRECT)
            begin
                q_entry.data = {{(fbrgb_pkg::ENTRY_DATA_W-24){1'b0}}, direct};
            end
            else
            begin
                q_entry.data = {{(fbrgb_pkg::ENTRY_DATA_W-16){1'b0}}, w};
            end
        end
    end

    always_comb
    begin
        fmt_next  = fmt_reg;
        rpix_next = rpix_reg;
        rwpp_next = rwpp_reg;
        if (cfg_hit)
        begin
            case (cfg_index)
                fbrgb_pkg::REG_PIXEL_FORMAT: fmt_next  = cfg_data[2:0];
                fbrgb_pkg::REG_ROW_PIXELS:   rpix_next = cfg_data[12:0];
                fbrgb_pkg::REG_ROW_WORDS:    rwpp_next = cfg_data[8:0];
                default:                     fmt_next  = fmt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= fbrgb_pkg::FMT_RGB24;
            rpix_reg  <= 13'd640;
            rwpp_reg  <= 9'd40;
            col_reg   <= '0;
            rwc_reg   <= '0;
            wig_reg   <= '0;
            stage_reg <= '0;
            scnt_reg  <= '0;
        end
        else
        begin
            fmt_reg  <= fmt_next;
            rpix_reg <= rpix_next;
            rwpp_reg <= rwpp_next;
            if (cfg_hit || (data_acc && restart))
            begin
                col_reg   <= '0;
                rwc_reg   <= '0;
                wig_reg   <= '0;
                stage_reg <= '0;
                scnt_reg  <= '0;
            end
            else if (data_acc)
            begin
                col_reg   <= col_next;
                rwc_reg   <= rwc_next;
                wig_reg   <= wig_next;
                stage_reg <= stage_next;
                scnt_reg  <= scnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_acc)
        begin
            pbuf_reg[wig_reg] <= w;
        end
    end

endmodule

>>> src/fbrgb_queue.sv
// ----------------------------------------------------------------------------
// fbrgb_queue
// Short first-in first-out queue of pixel batches and palette writes
// between the front and back parts.
// ----------------------------------------------------------------------------
module fbrgb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fbrgb_pkg::q_entry_t   push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output fbrgb_pkg::q_entry_t   head
);

    fbrgb_pkg::q_entry_t               mem_reg [fbrgb_pkg::QUEUE_DEPTH];
    logic [fbrgb_pkg::QUEUE_AW-1:0]    wptr_reg, rptr_reg;
    logic [fbrgb_pkg::QUEUE_AW:0]      count_reg, count_next;

    assign full       = (count_reg == (fbrgb_pkg::QUEUE_AW+1)'(fbrgb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/fbrgb_back.sv
// ----------------------------------------------------------------------------
// fbrgb_back
// Takes pixel batches from the queue, walks their pixels one per cycle unless
// stalled, writes and looks up the palette and holds the output register.
// ----------------------------------------------------------------------------
module fbrgb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  fbrgb_pkg::q_entry_t   q_head,
    output logic                  q_pop,
    output logic                  pix_valid,
    input  logic                  pix_stall,
    output fbrgb_pkg::out_item_t  pix_data
);

    fbrgb_pkg::q_entry_t          a_entry_reg;
    logic                         a_valid_reg;
    logic [3:0]                   a_pix_reg;

    logic                         b_valid_reg;
    logic                         b_lookup_reg;
    logic                         b_oob_reg;
    logic [23:0]                  b_color_reg;
    logic                         b_single_reg;
    logic                         b_row_end_reg;
    logic                         b_batch_end_reg;

    logic                         a_is_pal;
    logic                         b_ready;
    logic                         a_fire;
    logic                         a_last;
    logic                         a_done;
    logic [15:0]                  word0;
    logic [7:0]                   pel;
    logic [7:0]                   idx;
    logic                         lookup;
    logic [23:0]                  color;
    logic                         single;
    logic                         pal_we;
    logic [7:0]                   pal_windex;
    logic [fbrgb_pkg::PAL_AW-1:0] pal_waddr;
    logic [fbrgb_pkg::PAL_AW-1:0] pal_raddr;
    logic [23:0]                  pal_rdata;

    assign a_is_pal = (a_entry_reg.op == fbrgb_pkg::OP_PALETTE);
    assign b_ready  = !b_valid_reg || !pix_stall;
    assign a_fire   = a_valid_reg && (a_is_pal || b_ready);
    assign a_last   = (a_pix_reg == a_entry_reg.last_pix);
    assign a_done   = a_fire && (a_is_pal || a_last);
    assign q_pop    = q_valid && (!a_valid_reg || a_done);
    assign word0    = a_entry_reg.data[15:0];

    always_comb
    begin
        for (int k = 0; k < fbrgb_pkg::MAX_PLANES; k++)
        begin
            pel[k] = (4'(k) < (4'd1 << a_entry_reg.plane_log)) &&
                     a_entry_reg.data[k*fbrgb_pkg::WORD_W + 15 - int'(a_pix_reg)];
        end
    end

    always_comb
    begin
        lookup = 1'b0;
        idx    = 8'd0;
        single = 1'b0;
        color  = a_entry_reg.data[23:0];
        case (a_entry_reg.op)
            fbrgb_pkg::OP_MONO:
            begin
                single = 1'b1;
                color  = word0[4'd15 - a_pix_reg] ? 24'h000000 : 24'hffffff;
            end
            fbrgb_pkg::OP_PLANAR:
            begin
                lookup = 1'b1;
                idx    = pel;
            end
            fbrgb_pkg::OP_CHUNKY:
            begin
                lookup = 1'b1;
                idx    = (a_pix_reg == 4'd0) ? word0[15:8] : word0[7:0];
            end
            default:
            begin
                lookup = 1'b0;
            end
        endcase
    end

    assign pal_windex = a_entry_reg.data[31:24];
    assign pal_we     = a_valid_reg && a_is_pal &&
                        ({1'b0, pal_windex} < 9'(fbrgb_pkg::PALETTE_ENTRIES));
    assign pal_waddr  = pal_windex[fbrgb_pkg::PAL_AW-1:0];
    assign pal_raddr  = idx[fbrgb_pkg::PAL_AW-1:0];

    fbrgb_ram #(
        .WIDTH (24),
        .DEPTH (fbrgb_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (a_entry_reg.data[23:0]),
        .re    (a_fire && !a_is_pal),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_pix_reg   <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                a_valid_reg <= 1'b1;
                a_pix_reg   <= '0;
            end
            else if (a_done)
            begin
                a_valid_reg <= 1'b0;
            end
            else if (a_fire)
            begin
                a_pix_reg <= a_pix_reg + 4'd1;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_fire && !a_is_pal;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_entry_reg <= q_head;
        end
        if (a_fire && !a_is_pal)
        begin
            b_lookup_reg    <= lookup;
            b_oob_reg       <= ({1'b0, idx} >= 9'(fbrgb_pkg::PALETTE_ENTRIES));
            b_color_reg     <= color;
            b_single_reg    <= single;
            b_row_end_reg   <= a_last && a_entry_reg.row_end;
            b_batch_end_reg <= a_last;
        end
    end

    always_comb
    begin
        pix_data                  = '0;
        if (b_lookup_reg)
        begin
            {pix_data.red, pix_data.green, pix_data.blue} = b_oob_reg ? 24'd0 : pal_rdata;
        end
        else
        begin
            {pix_data.red, pix_data.green, pix_data.blue} = b_color_reg;
        end
        pix_data.single_component = b_single_reg;
        pix_data.row_end          = b_row_end_reg;
        pix_data.batch_end        = b_batch_end_reg;
    end

    assign pix_valid = b_valid_reg;

endmodule

>>> src/framebuffer_row_to_rgb888.sv
// ----------------------------------------------------------------------------
// framebuffer_row_to_rgb888
// Converts framebuffer words of a selected format into RGB888 pixels.
// A word's first pixel passes the batch queue and the back part's batch and
// output registers. Throughput: one pixel per cycle while pix_stall is low,
// set by the back part's pixel walk and the single palette read port; a source
// word is taken every cycle while the four-entry batch queue has room.
// Reset clears configuration to defaults and the row position; the palette
// holds no defined contents until written.
// ----------------------------------------------------------------------------
module framebuffer_row_to_rgb888 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  fbrgb_pkg::in_item_t             src_data,
    output logic                            pix_valid,
    input  logic                            pix_stall,
    output fbrgb_pkg::out_item_t            pix_data,
    input  logic                            cfg_write_en,
    input  logic [fbrgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbrgb_pkg::CFG_W-1:0]     cfg_data
);

    logic                 q_full;
    logic                 q_push;
    fbrgb_pkg::q_entry_t  q_entry;
    logic                 q_pop;
    logic                 q_valid;
    fbrgb_pkg::q_entry_t  q_head;

    fbrgb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .src_data     (src_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    fbrgb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    fbrgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

endmodule
